[rtl/core/dnd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_pkg
// shared constants, codes and controller/datapath handshake types for the
// dns name decompressor
// ----------------------------------------------------------------------------
package dnd_pkg;

    localparam int PACKET_BYTES_DEF = 512;
    localparam int NAME_BYTES       = 256;
    localparam int NAME_AW          = 8;
    localparam int CHUNK_CHARS      = 8;

    localparam logic [7:0] LABEL_MAX = 8'd63;
    localparam logic [5:0] PTR_MASK  = 6'h3f;
    localparam logic [7:0] DOT_CHAR  = 8'h2e;

    localparam logic [8:0] NAME_LIMIT_RESET = 9'd256;
    localparam logic [8:0] NAME_LIMIT_CAP   = 9'd256;
    localparam logic [4:0] MAX_HOPS_RESET   = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_NAME_LIMIT = 1'b0;
    localparam logic REG_MAX_HOPS   = 1'b1;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_TRUNC  = 3'd1;
    localparam status_t ST_BADPTR = 3'd2;
    localparam status_t ST_DEEP   = 3'd3;
    localparam status_t ST_LONG   = 3'd4;

    typedef struct packed {
        logic    load;
        logic    dec_start;
        logic    addr_plus1;
        logic    name_done;
        logic    ptr_save;
        logic    label_begin;
        logic    label_step;
        logic    name_wr;
        logic    name_dot;
        logic    ptr_follow;
        logic    err_set;
        status_t err_code;
        logic    gath_issue;
        logic    gath_recv;
        logic    chunk_next;
    } dp_cmd_t;

    typedef struct packed {
        logic start_oob;
        logic pos_oob;
        logic byte_zero;
        logic byte_ptr;
        logic ptr_trunc;
        logic lbl_trunc;
        logic lbl_long;
        logic tgt_bad;
        logic hops_deep;
        logic cnt_one;
        logic gath_more;
        logic out_last;
    } dp_status_t;

endpackage
`default_nettype wire

[rtl/core/dnd_channels.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd channels
// valid/ready channel interfaces for decompressor items and result chunks
// ----------------------------------------------------------------------------
interface dnd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_value;
    logic       last_byte;
    logic [8:0] start_offset;

    modport source (output valid, output mode, output byte_value, output last_byte,
                    output start_offset, input ready);
    modport sink (input valid, input mode, input byte_value, input last_byte,
                  input start_offset, output ready);
endinterface

interface dnd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] chars;
    logic [3:0]  char_count;
    logic        last;
    logic [2:0]  status;
    logic [9:0]  end_offset;

    modport source (output valid, output chars, output char_count, output last,
                    output status, output end_offset, input ready);
    modport sink (input valid, input chars, input char_count, input last,
                  input status, input end_offset, output ready);
endinterface
`default_nettype wire

[rtl/core/dnd_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_regs
// apb configuration registers: name length limit and pointer hop limit
// ----------------------------------------------------------------------------
module dnd_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [8:0]  name_limit,
    output logic [4:0]  max_hops
);

    logic [8:0] name_limit_reg;
    logic [4:0] max_hops_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_limit_reg <= dnd_pkg::NAME_LIMIT_RESET;
            max_hops_reg   <= dnd_pkg::MAX_HOPS_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == dnd_pkg::REG_NAME_LIMIT)
                name_limit_reg <= pwdata[8:0];
            else
                max_hops_reg <= pwdata[4:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == dnd_pkg::REG_MAX_HOPS)
            prdata = {27'd0, max_hops_reg};
        else
            prdata = {23'd0, name_limit_reg};
    end

    assign name_limit = name_limit_reg;
    assign max_hops   = max_hops_reg;

endmodule
`default_nettype wire

[rtl/core/dnd_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_datapath
// packet store, name buffer, walk pointers and chunk packing
// ----------------------------------------------------------------------------
module dnd_datapath #(
    parameter int PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dnd_pkg::dp_cmd_t     dp_cmd,
    output dnd_pkg::dp_status_t  dp_stat,
    input  logic [7:0]           byte_value,
    input  logic                 last_byte,
    input  logic [8:0]           start_offset,
    input  logic [8:0]           name_limit,
    input  logic [4:0]           max_hops,
    output logic [63:0]          chars,
    output logic [3:0]           char_count,
    output logic                 last,
    output logic [2:0]           status,
    output logic [9:0]           end_offset
);

    localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int LW = $clog2(PACKET_BYTES + 1);
    localparam int CW = ((LW > 14) ? LW : 14) + 2;
    localparam int NW = dnd_pkg::NAME_AW;

    logic [7:0] pkt_mem [PACKET_BYTES];
    logic [7:0] name_mem [dnd_pkg::NAME_BYTES];

    logic [7:0]    pkt_rdata_reg;
    logic [7:0]    name_rdata_reg;
    logic [AW-1:0] pkt_raddr;
    logic          name_we;
    logic [7:0]    name_wdata;

    logic [LW-1:0] load_pos_reg, load_pos_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [4:0]    hops_reg, hops_next;
    logic [NW-1:0] n_reg, n_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [5:0]    hi6_reg, hi6_next;
    logic [9:0]    endo_reg, endo_next;
    logic [NW-1:0] len_reg, len_next;
    logic [NW-1:0] rd_idx_reg, rd_idx_next;
    logic [3:0]    iss_reg, iss_next;
    logic [3:0]    fill_reg, fill_next;
    logic [63:0]   chunk_reg, chunk_next;
    dnd_pkg::status_t status_reg, status_next;

    logic          load_full;
    logic [LW-1:0] load_inc;
    logic [LW-1:0] pos_p1;
    logic [CW-1:0] pos_w, plen_w;
    logic [13:0]   target;
    logic [8:0]    lim;

    // packet store: one write port for loading, one registered read port
    assign load_full = load_pos_reg >= LW'(PACKET_BYTES);
    assign pos_p1    = pos_reg + LW'(1);
    assign pkt_raddr = dp_cmd.addr_plus1 ? pos_p1[AW-1:0] : pos_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load && !load_full)
            pkt_mem[load_pos_reg[AW-1:0]] <= byte_value;
        pkt_rdata_reg <= pkt_mem[pkt_raddr];
    end

    // name buffer: written while walking, read back while packing
    assign name_we    = dp_cmd.name_wr || dp_cmd.name_dot;
    assign name_wdata = dp_cmd.name_dot ? dnd_pkg::DOT_CHAR : pkt_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem[n_reg] <= name_wdata;
        name_rdata_reg <= name_mem[rd_idx_reg];
    end

    // checks
    assign pos_w  = CW'(pos_reg);
    assign plen_w = CW'(plen_reg);
    assign target = {hi6_reg, pkt_rdata_reg};
    assign lim    = (name_limit > dnd_pkg::NAME_LIMIT_CAP) ? dnd_pkg::NAME_LIMIT_CAP : name_limit;

    always_comb
    begin
        dp_stat.start_oob = CW'(start_offset) >= plen_w;
        dp_stat.pos_oob   = pos_w >= plen_w;
        dp_stat.byte_zero = pkt_rdata_reg == 8'd0;
        dp_stat.byte_ptr  = pkt_rdata_reg > dnd_pkg::LABEL_MAX;
        dp_stat.ptr_trunc = (pos_w + CW'(2)) > plen_w;
        dp_stat.lbl_trunc = (pos_w + CW'(pkt_rdata_reg) + CW'(1)) > plen_w;
        dp_stat.lbl_long  = (10'(n_reg) + 10'(pkt_rdata_reg) + 10'd1) >= 10'(lim);
        dp_stat.tgt_bad   = (target == 14'd0) || (CW'(target) >= plen_w);
        dp_stat.hops_deep = hops_reg >= max_hops;
        dp_stat.cnt_one   = cnt_reg == 6'd1;
        dp_stat.gath_more = (rd_idx_reg < len_reg) && (iss_reg < 4'(dnd_pkg::CHUNK_CHARS));
        dp_stat.out_last  = (status_reg != dnd_pkg::ST_OK) || (rd_idx_reg == len_reg);
    end

    assign load_inc = load_full ? load_pos_reg : load_pos_reg + LW'(1);

    always_comb
    begin
        load_pos_next = load_pos_reg;
        plen_next     = plen_reg;
        pos_next      = pos_reg;
        hops_next     = hops_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        hi6_next      = hi6_reg;
        endo_next     = endo_reg;
        len_next      = len_reg;
        rd_idx_next   = rd_idx_reg;
        iss_next      = iss_reg;
        fill_next     = fill_reg;
        chunk_next    = chunk_reg;
        status_next   = status_reg;

        if (dp_cmd.load)
        begin
            if (last_byte)
            begin
                plen_next     = load_inc;
                load_pos_next = '0;
            end
            else
                load_pos_next = load_inc;
        end

        if (dp_cmd.dec_start)
        begin
            pos_next    = LW'(start_offset);
            hops_next   = '0;
            n_next      = '0;
            status_next = dnd_pkg::ST_OK;
        end

        if (dp_cmd.label_begin)
        begin
            pos_next = pos_p1;
            cnt_next = pkt_rdata_reg[5:0];
        end

        if (dp_cmd.label_step)
        begin
            pos_next = pos_p1;
            cnt_next = cnt_reg - 6'd1;
        end

        if (dp_cmd.ptr_save)
            hi6_next = pkt_rdata_reg[5:0] & dnd_pkg::PTR_MASK;

        if (dp_cmd.ptr_follow)
        begin
            if (hops_reg == 5'd0)
                endo_next = 10'(pos_w + CW'(2));
            hops_next = hops_reg + 5'd1;
            pos_next  = LW'(target);
        end

        if (name_we)
            n_next = n_reg + NW'(1);

        if (dp_cmd.name_done)
        begin
            if (hops_reg == 5'd0)
                endo_next = 10'(pos_w + CW'(1));
            len_next    = (n_reg == '0) ? '0 : n_reg - NW'(1);
            rd_idx_next = '0;
            iss_next    = '0;
            fill_next   = '0;
            chunk_next  = '0;
        end

        if (dp_cmd.err_set)
        begin
            status_next = dp_cmd.err_code;
            chunk_next  = '0;
            fill_next   = '0;
        end

        if (dp_cmd.gath_issue)
        begin
            rd_idx_next = rd_idx_reg + NW'(1);
            iss_next    = iss_reg + 4'd1;
        end

        if (dp_cmd.gath_recv)
        begin
            chunk_next[{fill_reg[2:0], 3'b000} +: 8] = name_rdata_reg;
            fill_next = fill_reg + 4'd1;
        end

        if (dp_cmd.chunk_next)
        begin
            chunk_next = '0;
            fill_next  = '0;
            iss_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            plen_reg     <= '0;
            pos_reg      <= '0;
            hops_reg     <= '0;
            n_reg        <= '0;
            cnt_reg      <= '0;
            len_reg      <= '0;
            rd_idx_reg   <= '0;
            iss_reg      <= '0;
            fill_reg     <= '0;
            status_reg   <= dnd_pkg::ST_OK;
        end
        else
        begin
            load_pos_reg <= load_pos_next;
            plen_reg     <= plen_next;
            pos_reg      <= pos_next;
            hops_reg     <= hops_next;
            n_reg        <= n_next;
            cnt_reg      <= cnt_next;
            len_reg      <= len_next;
            rd_idx_reg   <= rd_idx_next;
            iss_reg      <= iss_next;
            fill_reg     <= fill_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi6_reg   <= hi6_next;
        endo_reg  <= endo_next;
        chunk_reg <= chunk_next;
    end

    assign chars      = chunk_reg;
    assign char_count = fill_reg;
    assign last       = dp_stat.out_last;
    assign status     = status_reg;
    assign end_offset = (dp_stat.out_last && status_reg == dnd_pkg::ST_OK) ? endo_reg : 10'd0;

endmodule
`default_nettype wire

[rtl/core/dnd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dnd_ctrl
// sequencer for loading, label walking, pointer hops and chunk output
// ----------------------------------------------------------------------------
module dnd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_mode,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  dnd_pkg::dp_status_t dp_stat,
    output dnd_pkg::dp_cmd_t    dp_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_HEAD  = 4'd2;
    localparam logic [3:0] S_PTR   = 4'd3;
    localparam logic [3:0] S_LBL   = 4'd4;
    localparam logic [3:0] S_LTAIL = 4'd5;
    localparam logic [3:0] S_DOT   = 4'd6;
    localparam logic [3:0] S_GATH  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       lbl_pend_reg;
    logic       gath_pend_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_EMIT;

    always_comb
    begin
        dp_cmd     = '0;
        state_next = state_reg;

        // label bytes land in the cycle after their read
        dp_cmd.name_wr   = lbl_pend_reg;
        dp_cmd.gath_recv = gath_pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!in_mode)
                        dp_cmd.load = 1'b1;
                    else if (dp_stat.start_oob)
                    begin
                        dp_cmd.err_set  = 1'b1;
                        dp_cmd.err_code = dnd_pkg::ST_TRUNC;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        dp_cmd.dec_start = 1'b1;
                        state_next       = S_FETCH;
                    end
                end
            end

            S_FETCH:
                state_next = S_HEAD;

            S_HEAD:
            begin
                priority if (dp_stat.pos_oob)
                begin
                    dp_cmd.err_set  = 1'b1;
                    dp_cmd.err_code = dnd_pkg::ST_TRUNC;
                    state_next      = S_EMIT;
                end
                else if (dp_stat.byte_zero)
                begin
                    dp_cmd.name_done = 1'b1;
                    state_next       = S_GATH;
                end
                else if (dp_stat.byte_ptr)
                begin
                    if (dp_stat.ptr_trunc)
                    begin
                        dp_cmd.err_set  = 1'b1;
                        dp_cmd.err_code = dnd_pkg::ST_TRUNC;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        dp_cmd.addr_plus1 = 1'b1;
                        dp_cmd.ptr_save   = 1'b1;
                        state_next        = S_PTR;
                    end
                end
                else if (dp_stat.lbl_trunc)
                begin
                    dp_cmd.err_set  = 1'b1;
                    dp_cmd.err_code = dnd_pkg::ST_TRUNC;
                    state_next      = S_EMIT;
                end
                else if (dp_stat.lbl_long)
                begin
                    dp_cmd.err_set  = 1'b1;
                    dp_cmd.err_code = dnd_pkg::ST_LONG;
                    state_next      = S_EMIT;
                end
                else
                begin
                    dp_cmd.label_begin = 1'b1;
                    state_next         = S_LBL;
                end
            end

            S_PTR:
            begin
                priority if (dp_stat.tgt_bad)
                begin
                    dp_cmd.err_set  = 1'b1;
                    dp_cmd.err_code = dnd_pkg::ST_BADPTR;
                    state_next      = S_EMIT;
                end
                else if (dp_stat.hops_deep)
                begin
                    dp_cmd.err_set  = 1'b1;
                    dp_cmd.err_code = dnd_pkg::ST_DEEP;
                    state_next      = S_EMIT;
                end
                else
                begin
                    dp_cmd.ptr_follow = 1'b1;
                    state_next        = S_FETCH;
                end
            end

            S_LBL:
            begin
                dp_cmd.label_step = 1'b1;
                if (dp_stat.cnt_one)
                    state_next = S_LTAIL;
            end

            S_LTAIL:
                state_next = S_DOT;

            // separator write, next length byte read in the same cycle
            S_DOT:
            begin
                dp_cmd.name_dot = 1'b1;
                state_next      = S_HEAD;
            end

            S_GATH:
            begin
                dp_cmd.gath_issue = dp_stat.gath_more;
                if (!dp_stat.gath_more && !gath_pend_reg)
                    state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (dp_stat.out_last)
                        state_next = S_IDLE;
                    else
                    begin
                        dp_cmd.chunk_next = 1'b1;
                        state_next        = S_GATH;
                    end
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lbl_pend_reg  <= 1'b0;
            gath_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lbl_pend_reg  <= dp_cmd.label_step;
            gath_pend_reg <= dp_cmd.gath_issue;
        end
    end

endmodule
`default_nettype wire

[rtl/core/dns_name_decompress.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_decompress
// loads a packet byte by byte and decodes compressed dns names into chunks
// ----------------------------------------------------------------------------
// A load item stores one byte per cycle while idle and is taken in the cycle
// it arrives. A decode item walks the name one stored byte per cycle through
// the single read port of the packet store: FETCH to start; per label HEAD, LBL
// per label byte, LTAIL and DOT; per compression pointer HEAD, PTR and FETCH.
// The packed name is read back from the name buffer at one character per
// cycle, pausing while a chunk waits, and the block returns to idle after the
// last chunk transfer. A failed decode ends at the failing byte and gives a
// single status transfer. No new item is taken while a decode is under way.
// ----------------------------------------------------------------------------
module dns_name_decompress #(
    parameter int PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dnd_in_if.sink      in_ch,
    dnd_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dnd_pkg::dp_cmd_t    dp_cmd;
    dnd_pkg::dp_status_t dp_stat;
    logic [8:0]          name_limit;
    logic [4:0]          max_hops;

    dnd_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .name_limit (name_limit),
        .max_hops   (max_hops)
    );

    dnd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_mode   (in_ch.mode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    dnd_datapath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .byte_value   (in_ch.byte_value),
        .last_byte    (in_ch.last_byte),
        .start_offset (in_ch.start_offset),
        .name_limit   (name_limit),
        .max_hops     (max_hops),
        .chars        (out_ch.chars),
        .char_count   (out_ch.char_count),
        .last         (out_ch.last),
        .status       (out_ch.status),
        .end_offset   (out_ch.end_offset)
    );

endmodule
`default_nettype wire

[sim/dns_name_checker.sv]
// ----------------------------------------------------------------------------
// dns_name_checker
// watches the item, chunk and register channels, keeps its own packet copy
// and compares every chunk transfer with the oldest one still awaited
// ----------------------------------------------------------------------------
module dns_name_checker (
    input  logic        clk,
    input  logic        rst_n,
    dnd_in_if           in_mon,
    dnd_out_if          out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [63:0]      chars;
        logic [3:0]       char_count;
        logic             last;
        dnd_pkg::status_t status;
        logic [9:0]       end_offset;
    } chunk_t;

    logic [7:0] packet_copy [dnd_pkg::PACKET_BYTES_DEF];
    logic [7:0] name_text [dnd_pkg::NAME_BYTES];
    int         stored_len;
    int         fill_pos;
    logic [8:0] name_limit;
    logic [4:0] max_hops;
    chunk_t     expected_chunks [$];
    int         failures = 0;

    // follows labels and pointers from start, leaves the dotted text in name_text
    function automatic dnd_pkg::status_t walk_name(input int start, output int name_len,
                                                   output int end_off);
        int               pos;
        int               lim;
        int               hops;
        int               n;
        int               b;
        int               target;
        logic             done;
        dnd_pkg::status_t st;
        pos     = start;
        lim     = (name_limit > 9'd256) ? 256 : int'(name_limit);
        hops    = 0;
        n       = 0;
        end_off = 0;
        st      = dnd_pkg::ST_OK;
        done    = 1'b0;
        while (!done)
        begin
            if (pos >= stored_len)
            begin
                st   = dnd_pkg::ST_TRUNC;
                done = 1'b1;
            end
            else
            begin
                b = packet_copy[pos];
                if (b == 0)
                begin
                    if (hops == 0)
                        end_off = pos + 1;
                    done = 1'b1;
                end
                else if (b > int'(dnd_pkg::LABEL_MAX))
                begin
                    if (stored_len - pos < 2)
                    begin
                        st   = dnd_pkg::ST_TRUNC;
                        done = 1'b1;
                    end
                    else
                    begin
                        target = ((b & int'(dnd_pkg::PTR_MASK)) << 8)
                                 | int'(packet_copy[pos + 1]);
                        if (target == 0 || target >= stored_len)
                        begin
                            st   = dnd_pkg::ST_BADPTR;
                            done = 1'b1;
                        end
                        else
                        begin
                            if (hops == 0)
                                end_off = pos + 2;
                            hops++;
                            if (hops > int'(max_hops))
                            begin
                                st   = dnd_pkg::ST_DEEP;
                                done = 1'b1;
                            end
                            else
                            begin
                                pos = target;
                            end
                        end
                    end
                end
                else if (stored_len - pos < b + 1)
                begin
                    st   = dnd_pkg::ST_TRUNC;
                    done = 1'b1;
                end
                else if (n + b + 1 >= lim)
                begin
                    st   = dnd_pkg::ST_LONG;
                    done = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < b; i++)
                        name_text[n + i] = packet_copy[pos + 1 + i];
                    name_text[n + b] = dnd_pkg::DOT_CHAR;
                    n   += b + 1;
                    pos += b + 1;
                end
            end
        end
        if (n > 0)
            n--;
        name_len = n;
        return st;
    endfunction

    function automatic void predict_chunks(input logic [8:0] start);
        dnd_pkg::status_t st;
        int               len;
        int               endo;
        int               chunks;
        chunk_t           c;
        st = walk_name(int'(start), len, endo);
        if (st != dnd_pkg::ST_OK)
        begin
            c        = '0;
            c.last   = 1'b1;
            c.status = st;
            expected_chunks.insert(expected_chunks.size(), c);
            return;
        end
        chunks = (len == 0) ? 1 : (len + 7) / 8;
        for (int k = 0; k < chunks; k++)
        begin
            c = '0;
            for (int i = 0; i < dnd_pkg::CHUNK_CHARS; i++)
            begin
                if (k * 8 + i < len)
                begin
                    c.chars[8 * i +: 8] = name_text[k * 8 + i];
                    c.char_count++;
                end
            end
            c.last       = (k == chunks - 1);
            c.status     = dnd_pkg::ST_OK;
            c.end_offset = c.last ? endo[9:0] : 10'd0;
            expected_chunks.insert(expected_chunks.size(), c);
        end
    endfunction

    function automatic void compare_chunk(input chunk_t got);
        chunk_t want;
        if (expected_chunks.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected chunk transfer: chars %h count %0d last %0d %s",
                         got.chars, got.char_count, got.last,
                         $sformatf("status %0d end %0d", got.status, got.end_offset));
            return;
        end
        want = expected_chunks.pop_front();
        if (got.chars !== want.chars || got.char_count !== want.char_count ||
            got.last !== want.last || got.status !== want.status ||
            got.end_offset !== want.end_offset)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("chunk mismatch: expected chars %h count %0d last %0d %s",
                         want.chars, want.char_count, want.last,
                         $sformatf("status %0d end %0d", want.status, want.end_offset));
                $display("                got chars %h count %0d last %0d %s",
                         got.chars, got.char_count, got.last,
                         $sformatf("status %0d end %0d", got.status, got.end_offset));
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_len = 0;
            fill_pos   = 0;
            name_limit = dnd_pkg::NAME_LIMIT_RESET;
            max_hops   = dnd_pkg::MAX_HOPS_RESET;
            expected_chunks.delete();
            pending    <= 0;
            fail_count <= failures;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == dnd_pkg::REG_NAME_LIMIT)
                    name_limit = pwdata[8:0];
                else
                    max_hops = pwdata[4:0];
            end
            if (out_mon.valid && out_mon.ready)
                compare_chunk({out_mon.chars, out_mon.char_count, out_mon.last,
                               out_mon.status, out_mon.end_offset});
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.mode)
                begin
                    predict_chunks(in_mon.start_offset);
                end
                else
                begin
                    if (fill_pos < dnd_pkg::PACKET_BYTES_DEF)
                    begin
                        packet_copy[fill_pos] = in_mon.byte_value;
                        fill_pos++;
                    end
                    if (in_mon.last_byte)
                    begin
                        stored_len = fill_pos;
                        fill_pos   = 0;
                    end
                end
            end
            pending    <= expected_chunks.size();
            fail_count <= failures;
        end
    end

endmodule

[sim/tb_dns_name_decompress.sv]
// ----------------------------------------------------------------------------
// tb_dns_name_decompress
// hand-built and random packets decoded under several register settings,
// with random gaps on the item side and random stalls on the chunk side
// ----------------------------------------------------------------------------
module tb_dns_name_decompress;

    localparam int IDLE_PCT       = 22;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 140;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic        steady = 1'b0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          fail_count;
    int          pending;
    logic [7:0]  packet_bytes [$];
    int          name_starts [$];

    dnd_in_if  name_in ();
    dnd_out_if chunk_out ();

    dns_name_decompress u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (name_in),
        .out_ch  (chunk_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dns_name_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (name_in),
        .out_mon    (chunk_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        chunk_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if ((name_in.valid && name_in.ready) || (chunk_out.valid && chunk_out.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic mode, input logic [7:0] value, input logic last_b,
                             input logic [8:0] offset);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            name_in.valid <= 1'b0;
            @(posedge clk);
        end
        name_in.valid        <= 1'b1;
        name_in.mode         <= mode;
        name_in.byte_value   <= value;
        name_in.last_byte    <= last_b;
        name_in.start_offset <= offset;
        do @(posedge clk); while (!name_in.ready);
        items_sent++;
    endtask

    task automatic load_packet();
        for (int i = 0; i < packet_bytes.size(); i++)
            send_item(1'b0, packet_bytes[i], i == packet_bytes.size() - 1,
                      9'($urandom_range(511)));
    endtask

    task automatic decode_at(input int offset);
        send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), offset[8:0]);
    endtask

    // let every awaited chunk arrive, then a short settle
    task automatic wait_idle();
        name_in.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_limits(input int limit, input int hops);
        wait_idle();
        write_reg(dnd_pkg::REG_NAME_LIMIT, limit);
        write_reg(dnd_pkg::REG_MAX_HOPS, hops);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        packet_bytes.insert(packet_bytes.size(), b);
    endfunction

    function automatic void push_label(input int len, input logic [7:0] fill);
        add_byte(len[7:0]);
        for (int i = 0; i < len; i++)
            add_byte((fill == 8'h00) ? 8'($urandom_range(255)) : fill);
    endfunction

    function automatic void push_text(input string s);
        add_byte(8'(s.len()));
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void push_pointer(input int target);
        add_byte({2'b11, target[13:8]});
        add_byte(target[7:0]);
    endfunction

    // mostly well-formed names chained by pointers to earlier names
    function automatic void build_packet(input int target_len);
        int start;
        int labels;
        int r;
        int cut;
        packet_bytes.delete();
        name_starts.delete();
        while (packet_bytes.size() < target_len)
        begin
            start = packet_bytes.size();
            name_starts.insert(name_starts.size(), start);
            if ($urandom_range(99) < 15 && name_starts.size() > 1)
            begin
                push_pointer(name_starts[$urandom_range(name_starts.size() - 2)]);
            end
            else
            begin
                labels = $urandom_range(4);
                for (int l = 0; l < labels; l++)
                    push_label(($urandom_range(99) < 80) ? $urandom_range(12, 1)
                                                          : $urandom_range(63, 13), 8'h00);
                r = $urandom_range(99);
                if (r < 55 || name_starts.size() < 2)
                    add_byte(8'h00);
                else if (r < 88)
                    push_pointer(name_starts[$urandom_range(name_starts.size() - 2)]);
                else if (r < 96)
                    push_pointer($urandom_range(packet_bytes.size()));
                else
                    push_pointer($urandom_range(16383));
            end
        end
        if ($urandom_range(99) < 10)
        begin
            cut = $urandom_range(3, 1);
            repeat (cut) packet_bytes.delete(packet_bytes.size() - 1);
        end
        if ($urandom_range(99) < 5)
            packet_bytes[$urandom_range(packet_bytes.size() - 1)] = 8'($urandom_range(255));
    endfunction

    function automatic int pick_offset();
        int r;
        int off;
        r = $urandom_range(99);
        if (r < 70 && name_starts.size() > 0)
            off = name_starts[$urandom_range(name_starts.size() - 1)];
        else if (r < 90)
            off = $urandom_range(packet_bytes.size() - 1);
        else
            off = $urandom_range(511);
        return (off > 511) ? $urandom_range(511) : off;
    endfunction

    initial
    begin
        int random_start;
        int phase;
        int decodes;
        name_in.valid        = 1'b0;
        name_in.mode         = 1'b0;
        name_in.byte_value   = '0;
        name_in.last_byte    = 1'b0;
        name_in.start_offset = '0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // no packet closed yet
        decode_at(0);

        // hand-built packet covering each special case
        packet_bytes.delete();
        push_text("www");
        push_text("example");
        push_text("com");
        add_byte(8'h00);
        push_text("foo");
        push_pointer(4);
        push_pointer(0);
        add_byte(8'hff);
        add_byte(8'hff);
        add_byte(8'h00);
        push_pointer(28);
        push_label(63, 8'h61);
        add_byte(8'h00);
        push_text("abc");
        packet_bytes[95] = 8'h05;
        add_byte(8'hc1);
        load_packet();
        decode_at(0);
        decode_at(4);
        decode_at(17);
        decode_at(23);
        decode_at(25);
        decode_at(27);
        decode_at(28);
        decode_at(30);
        decode_at(95);
        decode_at(99);
        decode_at(100);
        decode_at(511);
        decode_at(1);

        set_limits(1, 0);
        decode_at(0);
        decode_at(27);
        decode_at(28);
        decode_at(17);

        set_limits(256, 31);
        decode_at(28);

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(5))
                0: set_limits(256, 16);
                1: set_limits(1, 0);
                2: set_limits(256, 31);
                3: set_limits($urandom_range(256, 1), $urandom_range(31));
                4: set_limits($urandom_range(100, 20), $urandom_range(4));
                default: wait_idle();
            endcase
            steady = (phase == 2);
            build_packet(($urandom_range(99) < 90) ? $urandom_range(60, 16)
                                                   : $urandom_range(300, 120));
            load_packet();
            decodes = $urandom_range(20, 10);
            for (int d = 0; d < decodes; d++)
                decode_at(pick_offset());
            phase++;
        end
        steady = 1'b0;

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
